// ===== rtl/core/fcct_pkg.sv =====
// ----------------------------------------------------------------------------
// fcct_pkg
// Shared types and constants of the cluster chain table: entry marks,
// operation and status codes, and the request and result payloads.
// ----------------------------------------------------------------------------
package fcct_pkg;

    localparam int unsigned ENTRY_W    = 28;
    localparam int unsigned ROOT_INDEX = 2;

    localparam logic [ENTRY_W-1:0] EOC_MARK       = 28'hFFFFFFF;
    localparam logic [ENTRY_W-1:0] EOC_MIN        = 28'hFFFFFF8;
    localparam logic [ENTRY_W-1:0] RESERVED0_MARK = 28'hFFFFFF8;

    typedef enum logic [2:0] {
        OP_READ       = 3'd0,
        OP_WRITE      = 3'd1,
        OP_ALLOC      = 3'd2,
        OP_ALLOC_LINK = 3'd3,
        OP_FREE_CHAIN = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2,
        ST_LOOP    = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic [7:0]         cluster;
        logic [ENTRY_W-1:0] entry_value;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ENTRY_W-1:0] raw_entry;
        logic [ENTRY_W-1:0] next_cluster;
        logic [7:0]         allocated_cluster;
        logic [7:0]         freed_count;
    } rsp_t;

endpackage

// ===== rtl/core/fcct_stream_if.sv =====
// ----------------------------------------------------------------------------
// fcct_stream_if
// Valid/ready channel carrying one request or result payload per transfer.
// ----------------------------------------------------------------------------
interface fcct_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/core/fcct_ram.sv =====
// ----------------------------------------------------------------------------
// fcct_ram
// Generic simple dual-port RAM: one write port, one read port and
// registered read data.
// ----------------------------------------------------------------------------
module fcct_ram #(
    parameter int unsigned WIDTH = 28,
    parameter int unsigned DEPTH = 130
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/fat_cluster_chain_table.sv =====
// ----------------------------------------------------------------------------
// fat_cluster_chain_table
// Allocation table of 28-bit cluster entries with read, write, allocate,
// allocate-and-link and free-chain requests.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel and each one gives exactly one result on
// the rsp channel. The table lives in a single RAM with one write and one
// registered read port, so allocate, allocate-and-link and free chain are
// read-modify-write sequences.
// A read passes through the read and done states; a write or a rejected
// request goes straight to the done state. Allocate scans entries from
// cluster 3 (at most CLUSTER_COUNT - 1), allocate-and-link also links the
// given cluster to the new one, and free chain clears at most CLUSTER_COUNT.
// The scan and the chain walk visit one entry per cycle, bounded by the read
// port. One request is processed at a time.
// After reset a clearing pass writes the initial marks into all
// CLUSTER_COUNT + 2 entries, one per cycle, and no request is taken until it
// ends. A finished result waits in the output register while the receiver
// stalls; the next request is already accepted and processed meanwhile, and
// its result waits inside the block until the output register frees.
// ----------------------------------------------------------------------------
module fat_cluster_chain_table #(
    parameter int unsigned CLUSTER_COUNT = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    fcct_stream_if.sink   req,
    fcct_stream_if.source rsp
);

    localparam int unsigned DEPTH  = CLUSTER_COUNT + 2;
    localparam int unsigned IDX_W  = $clog2(DEPTH);
    localparam int unsigned STEP_W = $clog2(CLUSTER_COUNT + 1);
    localparam int unsigned EW     = fcct_pkg::ENTRY_W;

    localparam logic [28:0]      DEPTH_W29  = 29'(DEPTH);
    localparam logic [28:0]      ROOT_W29   = 29'(fcct_pkg::ROOT_INDEX);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(DEPTH - 1);
    localparam logic [IDX_W-1:0] ROOT_IDX   = IDX_W'(fcct_pkg::ROOT_INDEX);
    localparam logic [IDX_W-1:0] FIRST_SCAN = IDX_W'(fcct_pkg::ROOT_INDEX + 1);
    localparam logic [STEP_W-1:0] MAX_STEPS = STEP_W'(CLUSTER_COUNT);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_RD    = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_MARK  = 8'b0001_0000,
        S_WALK  = 8'b0010_0000,
        S_DONE  = 8'b0100_0000,
        S_SPARE = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic               hit_reg, hit_next;
    logic [EW-1:0]      fwd_reg, fwd_next;
    logic [2:0]         op_reg, op_next;
    logic [IDX_W-1:0]   src_reg, src_next;
    fcct_pkg::rsp_t     res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    fcct_pkg::rsp_t     out_data_reg, out_data_next;

    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [EW-1:0]      wdata;
    logic [IDX_W-1:0]   raddr;
    logic [EW-1:0]      rdata;

    logic [EW-1:0]      eff;
    logic [EW-1:0]      eff_next;
    logic [28:0]        cl29;
    logic [28:0]        n29;
    logic               cl_in_table;
    logic               cl_is_data;
    logic               n_is_data;
    logic [IDX_W-1:0]   cl_idx;
    logic [STEP_W-1:0]  steps_inc;
    logic [IDX_W+7:0]   alloc_ext;
    logic [STEP_W+7:0]  freed_ext;
    logic               in_ready;

    fcct_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // A read issued in the same cycle as a write to the same entry takes the
    // written value.
    assign eff       = hit_reg ? fwd_reg : rdata;
    assign eff_next  = (eff >= fcct_pkg::EOC_MIN) ? '0 : eff;
    assign cl29      = {21'b0, req.payload.cluster};
    assign n29       = {1'b0, eff_next};
    assign cl_in_table = cl29 < DEPTH_W29;
    assign cl_is_data  = (cl29 >= ROOT_W29) && cl_in_table;
    assign n_is_data   = (n29 >= ROOT_W29) && (n29 < DEPTH_W29);
    assign cl_idx    = cl29[IDX_W-1:0];
    assign steps_inc = steps_reg + STEP_W'(1);
    assign alloc_ext = {8'b0, cur_reg};
    assign freed_ext = {8'b0, steps_inc};

    assign req.ready   = in_ready;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        steps_next     = steps_reg;
        op_next        = op_reg;
        src_next       = src_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        we             = 1'b0;
        waddr          = cur_reg;
        wdata          = '0;
        raddr          = cur_reg;
        in_ready       = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                priority if (cur_reg == '0)
                begin
                    wdata = fcct_pkg::RESERVED0_MARK;
                end
                else if (cur_reg == IDX_W'(1) || cur_reg == ROOT_IDX)
                begin
                    wdata = fcct_pkg::EOC_MARK;
                end
                else
                begin
                    wdata = '0;
                end
                if (cur_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + IDX_W'(1);
                end
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (req.valid)
                begin
                    res_next   = '0;
                    op_next    = req.payload.operation;
                    src_next   = cl_idx;
                    state_next = S_DONE;
                    unique case (req.payload.operation)
                        fcct_pkg::OP_READ:
                        begin
                            if (cl_in_table)
                            begin
                                raddr      = cl_idx;
                                state_next = S_RD;
                            end
                            else
                            begin
                                res_next.status = fcct_pkg::ST_RANGE;
                            end
                        end
                        fcct_pkg::OP_WRITE:
                        begin
                            if (cl_in_table)
                            begin
                                we    = 1'b1;
                                waddr = cl_idx;
                                wdata = req.payload.entry_value;
                            end
                            else
                            begin
                                res_next.status = fcct_pkg::ST_RANGE;
                            end
                        end
                        fcct_pkg::OP_ALLOC, fcct_pkg::OP_ALLOC_LINK:
                        begin
                            if (req.payload.operation == fcct_pkg::OP_ALLOC_LINK
                                && !cl_is_data)
                            begin
                                res_next.status = fcct_pkg::ST_RANGE;
                            end
                            else
                            begin
                                raddr      = FIRST_SCAN;
                                cur_next   = FIRST_SCAN;
                                state_next = S_SCAN;
                            end
                        end
                        fcct_pkg::OP_FREE_CHAIN:
                        begin
                            if (cl_is_data)
                            begin
                                raddr      = cl_idx;
                                cur_next   = cl_idx;
                                steps_next = '0;
                                state_next = S_WALK;
                            end
                            else
                            begin
                                res_next.status = fcct_pkg::ST_RANGE;
                            end
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                res_next.raw_entry    = eff;
                res_next.next_cluster = eff_next;
                state_next            = S_DONE;
            end

            S_SCAN:
            begin
                if (eff == '0)
                begin
                    res_next.allocated_cluster = alloc_ext[7:0];
                    we = 1'b1;
                    if (op_reg == fcct_pkg::OP_ALLOC_LINK)
                    begin
                        waddr      = src_reg;
                        wdata      = EW'(cur_reg);
                        state_next = S_MARK;
                    end
                    else
                    begin
                        wdata      = fcct_pkg::EOC_MARK;
                        state_next = S_DONE;
                    end
                end
                else if (cur_reg == LAST_IDX)
                begin
                    res_next.status = fcct_pkg::ST_NOSPACE;
                    state_next      = S_DONE;
                end
                else
                begin
                    cur_next = cur_reg + IDX_W'(1);
                    raddr    = cur_reg + IDX_W'(1);
                end
            end

            S_MARK:
            begin
                we         = 1'b1;
                wdata      = fcct_pkg::EOC_MARK;
                state_next = S_DONE;
            end

            S_WALK:
            begin
                we    = 1'b1;
                wdata = '0;
                if (!n_is_data)
                begin
                    res_next.freed_count = freed_ext[7:0];
                    state_next           = S_DONE;
                end
                else if (steps_inc == MAX_STEPS)
                begin
                    res_next.status      = fcct_pkg::ST_LOOP;
                    res_next.freed_count = freed_ext[7:0];
                    state_next           = S_DONE;
                end
                else
                begin
                    cur_next   = eff_next[IDX_W-1:0];
                    raddr      = eff_next[IDX_W-1:0];
                    steps_next = steps_inc;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign hit_next = we && (waddr == raddr);
    assign fwd_next = wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cur_reg       <= '0;
            steps_reg     <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            steps_reg     <= steps_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_reg      <= fwd_next;
        op_reg       <= op_next;
        src_reg      <= src_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.payload.operation == fcct_pkg::OP_WRITE
        |=> state_reg == S_DONE)
        else $error("write request did not complete in one cycle");

    a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> cur_reg <= LAST_IDX && cur_reg >= FIRST_SCAN)
        else $error("allocation scan left the data clusters");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> steps_reg < MAX_STEPS)
        else $error("chain walk exceeded the table size");

    a_nospace_no_cluster: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.payload.status == fcct_pkg::ST_NOSPACE
        |-> rsp.payload.allocated_cluster == '0)
        else $error("cluster reported together with no free space");

    a_no_request_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg) == S_CLEAR && state_reg == S_CLEAR |-> !rsp.valid)
        else $error("result offered during the clearing pass");

endmodule
